// ----- rtl/assert_macros.svh -----
// Shared assertion shorthands; clk and rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ARQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ARQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/arq_pkg.sv -----
package arq_pkg;

  localparam int SEQ_W       = 3;
  localparam int WIN_DEPTH   = 4;
  localparam int WIN_IDX_W   = 2;
  localparam int PAY_W       = 32;
  localparam int CNT_W       = 16;
  localparam int MAX_RESULTS = 24;
  localparam int RES_IDX_W   = 5;

  typedef enum logic [2:0] {
    CMD_SEND      = 3'd0,
    CMD_FRAME     = 3'd1,
    CMD_TIMEOUT   = 3'd2,
    CMD_CKSUM_ERR = 3'd3,
    CMD_ACK_TMO   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_TX        = 3'd0,
    ACT_DELIVER   = 3'd1,
    ACT_START     = 3'd2,
    ACT_STOP      = 3'd3,
    ACT_START_ACK = 3'd4,
    ACT_STOP_ACK  = 3'd5,
    ACT_NONE      = 3'd6
  } act_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_PREP_SEND,
    OP_PREP_TMO,
    OP_PREP_RENAK,
    OP_DATA_TX,
    OP_START,
    OP_STOPACK,
    OP_CTL_TX,
    OP_CLR_OOO_SACK,
    OP_STORE,
    OP_DELIVER,
    OP_SACK,
    OP_ACK_STEP,
    OP_CHECK,
    OP_NONE,
    OP_POP
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DATA_TX,
    S_DATA_START,
    S_DATA_STOPACK,
    S_CTL_TX,
    S_CTL_STOPACK,
    S_RX_STORE,
    S_DELIVER,
    S_DELIV_SACK,
    S_ACK_LOOP,
    S_CHECK,
    S_FINISH,
    S_DRAIN
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   in_rdy;
    logic   out_vld;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] kind;
    logic       seq_is_low;
    logic       nak_allowed;
    logic       ooo;
    logic       store_ok;
    logic       deliver_ok;
    logic       nak_ok;
    logic       ack_ok;
    logic       res_empty;
    logic       res_last;
    logic       in_valid;
    logic       out_ready;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]       act;
    logic [1:0]       kind;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [PAY_W-1:0] pay;
    logic [SEQ_W-1:0] tseq;
  } res_t;

  // b lies in the circular window [a, c)
  function automatic logic in_window(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                     logic [SEQ_W-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic logic [WIN_IDX_W-1:0] win_idx(logic [SEQ_W-1:0] s);
    return s[WIN_IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/arq_in_if.sv -----
interface arq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [1:0]  rx_kind;
  logic [2:0]  rx_seq;
  logic [2:0]  rx_ack;
  logic [31:0] rx_payload;
  logic [31:0] app_payload;
  logic [2:0]  timed_out_seq;

  modport source (output valid, command, rx_kind, rx_seq, rx_ack, rx_payload,
                  app_payload, timed_out_seq, input ready);
  modport sink (input valid, command, rx_kind, rx_seq, rx_ack, rx_payload,
                app_payload, timed_out_seq, output ready);
endinterface

// ----- rtl/arq_out_if.sv -----
interface arq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  tx_kind;
  logic [2:0]  tx_seq;
  logic [2:0]  tx_ack;
  logic [31:0] payload;
  logic [2:0]  timer_seq;
  logic        transfer_done;
  logic        window_open;
  logic        last;

  modport source (output valid, action, tx_kind, tx_seq, tx_ack, payload, timer_seq,
                  transfer_done, window_open, last, input ready);
  modport sink (input valid, action, tx_kind, tx_seq, tx_ack, payload, timer_seq,
                transfer_done, window_open, last, output ready);
endinterface

// ----- rtl/arq_cfg_if.sv -----
interface arq_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/arq_ctrl.sv -----
module arq_ctrl
  import arq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd_o
);

  `include "assert_macros.svh"

  state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_o.op      = OP_NOP;
    cmd_o.in_rdy  = 1'b0;
    cmd_o.out_vld = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.in_rdy = 1'b1;
        if (stat.in_valid) begin
          cmd_o.op  = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_SEND: begin
            cmd_o.op  = OP_PREP_SEND;
            state_nxt = S_DATA_TX;
          end
          CMD_FRAME: begin
            priority if (stat.kind == KIND_DATA) begin
              if (stat.seq_is_low) begin
                cmd_o.op  = OP_CLR_OOO_SACK;
                state_nxt = S_RX_STORE;
              end else if (stat.nak_allowed) begin
                state_nxt = S_CTL_TX;
              end else begin
                state_nxt = S_RX_STORE;
              end
            end else if (stat.kind == KIND_NAK && stat.nak_ok) begin
              cmd_o.op  = OP_PREP_RENAK;
              state_nxt = S_DATA_TX;
            end else begin
              state_nxt = S_ACK_LOOP;
            end
          end
          CMD_TIMEOUT: begin
            cmd_o.op  = OP_PREP_TMO;
            state_nxt = S_DATA_TX;
          end
          CMD_CKSUM_ERR: state_nxt = stat.nak_allowed ? S_CTL_TX : S_FINISH;
          CMD_ACK_TMO:   state_nxt = S_CTL_TX;
          default:       state_nxt = S_FINISH;
        endcase
      end
      S_DATA_TX: begin
        cmd_o.op  = OP_DATA_TX;
        state_nxt = S_DATA_START;
      end
      S_DATA_START: begin
        cmd_o.op  = OP_START;
        state_nxt = S_DATA_STOPACK;
      end
      S_DATA_STOPACK: begin
        cmd_o.op  = OP_STOPACK;
        state_nxt = (stat.cmd == CMD_FRAME) ? S_ACK_LOOP : S_FINISH;
      end
      S_CTL_TX: begin
        cmd_o.op  = OP_CTL_TX;
        state_nxt = S_CTL_STOPACK;
      end
      S_CTL_STOPACK: begin
        cmd_o.op  = OP_STOPACK;
        state_nxt = (stat.cmd == CMD_FRAME) ? S_RX_STORE : S_CHECK;
      end
      S_RX_STORE: begin
        if (stat.store_ok) begin
          cmd_o.op  = OP_STORE;
          state_nxt = S_DELIVER;
        end else begin
          state_nxt = S_ACK_LOOP;
        end
      end
      S_DELIVER: begin
        if (stat.deliver_ok) begin
          cmd_o.op  = OP_DELIVER;
          state_nxt = S_DELIV_SACK;
        end else begin
          state_nxt = S_ACK_LOOP;
        end
      end
      S_DELIV_SACK: begin
        cmd_o.op  = OP_SACK;
        state_nxt = S_DELIVER;
      end
      S_ACK_LOOP: begin
        // one retired frame per cycle until the ack leaves the send window
        if (stat.ack_ok) begin
          cmd_o.op = OP_ACK_STEP;
        end else if ((stat.kind == KIND_DATA && stat.ooo) || stat.kind == KIND_ACK ||
                     stat.kind == KIND_NAK) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CHECK: begin
        cmd_o.op  = OP_CHECK;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.res_empty) cmd_o.op = OP_NONE;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.out_vld = 1'b1;
        if (stat.out_ready) begin
          cmd_o.op = OP_POP;
          if (stat.res_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `ARQ_ASSERT_IMP(a_rdy_vld_excl, cmd_o.in_rdy, !cmd_o.out_vld)
  `ARQ_ASSERT_NXT(a_busy_after_req, cmd_o.in_rdy && stat.in_valid, !cmd_o.in_rdy)
  `ARQ_ASSERT_IMP(a_drain_nonempty, state_r == S_DRAIN, !stat.res_empty)

endmodule

// ----- rtl/arq_dp.sv -----
module arq_dp
  import arq_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  dp_cmd_t        cmd_i,
  output dp_stat_t       stat,
  arq_in_if.sink         in_ch,
  arq_out_if.source      out_ch,
  arq_cfg_if.sink        cfg_ch
);

  `include "assert_macros.svh"

  logic [2:0]       cmd_r;
  logic [1:0]       kind_r;
  logic [SEQ_W-1:0] seq_r, ack_r, tseq_r, dseq_r;
  logic [PAY_W-1:0] rxp_r, appp_r;

  logic [SEQ_W-1:0] sle_r, sns_r, rle_r, rhe_r, outst_r;
  logic             nak_allowed_r, ooo_r, done_r;
  logic [CNT_W-1:0] completed_r, sent_r, fc_r;
  logic [WIN_DEPTH-1:0] marks_r;
  logic [PAY_W-1:0] rstore_r [WIN_DEPTH];
  logic [PAY_W-1:0] sstore_r [WIN_DEPTH];

  res_t               res_r [MAX_RESULTS];
  logic [RES_IDX_W-1:0] wcnt_r, rd_r;

  logic emit_en;
  res_t emit_d;
  logic [SEQ_W-1:0] tx_ack;

  assign tx_ack = rle_r - SEQ_W'(1);

  always_comb begin
    emit_en = 1'b1;
    emit_d  = '0;
    unique case (cmd_i.op)
      OP_DATA_TX: begin
        emit_d.act  = ACT_TX;
        emit_d.kind = KIND_DATA;
        emit_d.seq  = dseq_r;
        emit_d.ack  = tx_ack;
        emit_d.pay  = sstore_r[win_idx(dseq_r)];
      end
      OP_START: begin
        emit_d.act  = ACT_START;
        emit_d.tseq = dseq_r;
      end
      OP_STOPACK: emit_d.act = ACT_STOP_ACK;
      OP_CTL_TX: begin
        emit_d.act  = ACT_TX;
        emit_d.kind = (cmd_r == CMD_ACK_TMO) ? KIND_ACK : KIND_NAK;
        emit_d.ack  = tx_ack;
      end
      OP_CLR_OOO_SACK, OP_SACK: emit_d.act = ACT_START_ACK;
      OP_DELIVER: begin
        emit_d.act = ACT_DELIVER;
        emit_d.pay = rstore_r[win_idx(rle_r)];
      end
      OP_ACK_STEP: begin
        emit_d.act  = ACT_STOP;
        emit_d.tseq = sle_r;
      end
      OP_NONE: emit_d.act = ACT_NONE;
      default: emit_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sle_r         <= '0;
      sns_r         <= '0;
      rle_r         <= '0;
      rhe_r         <= SEQ_W'(WIN_DEPTH);
      outst_r       <= '0;
      nak_allowed_r <= 1'b1;
      ooo_r         <= 1'b0;
      done_r        <= 1'b0;
      completed_r   <= '0;
      sent_r        <= '0;
      fc_r          <= CNT_W'(1);
      marks_r       <= '0;
      wcnt_r        <= '0;
      rd_r          <= '0;
    end else begin
      if (cfg_ch.valid) fc_r <= cfg_ch.data;
      unique case (cmd_i.op)
        OP_LATCH: begin
          cmd_r  <= in_ch.command;
          kind_r <= in_ch.rx_kind;
          seq_r  <= in_ch.rx_seq;
          ack_r  <= in_ch.rx_ack;
          rxp_r  <= in_ch.rx_payload;
          appp_r <= in_ch.app_payload;
          tseq_r <= in_ch.timed_out_seq;
          wcnt_r <= '0;
          rd_r   <= '0;
        end
        OP_PREP_SEND: begin
          if (outst_r != '1) outst_r <= outst_r + SEQ_W'(1);
          sstore_r[win_idx(sns_r)] <= appp_r;
          dseq_r <= sns_r;
          sns_r  <= sns_r + SEQ_W'(1);
          if (sent_r != '1) sent_r <= sent_r + CNT_W'(1);
        end
        OP_PREP_TMO:   dseq_r <= tseq_r;
        OP_PREP_RENAK: dseq_r <= ack_r + SEQ_W'(1);
        OP_CTL_TX: begin
          if (cmd_r != CMD_ACK_TMO) nak_allowed_r <= 1'b0;
          if (cmd_r == CMD_FRAME) ooo_r <= 1'b1;
        end
        OP_CLR_OOO_SACK: ooo_r <= 1'b0;
        OP_STORE: begin
          marks_r[win_idx(seq_r)]  <= 1'b1;
          rstore_r[win_idx(seq_r)] <= rxp_r;
        end
        OP_DELIVER: begin
          nak_allowed_r           <= 1'b1;
          marks_r[win_idx(rle_r)] <= 1'b0;
          rle_r <= rle_r + SEQ_W'(1);
          rhe_r <= rhe_r + SEQ_W'(1);
          if (completed_r != '1) completed_r <= completed_r + CNT_W'(1);
        end
        OP_ACK_STEP: begin
          if (outst_r != '0) outst_r <= outst_r - SEQ_W'(1);
          sle_r <= sle_r + SEQ_W'(1);
          if (completed_r != '1) completed_r <= completed_r + CNT_W'(1);
        end
        OP_CHECK: if (completed_r == fc_r) done_r <= 1'b1;
        OP_POP:   rd_r <= rd_r + RES_IDX_W'(1);
        default: ;
      endcase
      if (emit_en && wcnt_r < RES_IDX_W'(MAX_RESULTS)) begin
        res_r[wcnt_r] <= emit_d;
        wcnt_r        <= wcnt_r + RES_IDX_W'(1);
      end
    end
  end

  assign stat.cmd         = cmd_r;
  assign stat.kind        = kind_r;
  assign stat.seq_is_low  = (seq_r == rle_r);
  assign stat.nak_allowed = nak_allowed_r;
  assign stat.ooo         = ooo_r;
  assign stat.store_ok    = in_window(rle_r, seq_r, rhe_r) && !marks_r[win_idx(seq_r)];
  assign stat.deliver_ok  = marks_r[win_idx(rle_r)];
  assign stat.nak_ok      = in_window(sle_r, ack_r + SEQ_W'(1), sns_r);
  assign stat.ack_ok      = in_window(sle_r, ack_r, sns_r);
  assign stat.res_empty   = (wcnt_r == '0);
  assign stat.res_last    = (rd_r == wcnt_r - RES_IDX_W'(1));
  assign stat.in_valid    = in_ch.valid;
  assign stat.out_ready   = out_ch.ready;

  // nothing is taken while reset is held
  assign in_ch.ready  = cmd_i.in_rdy && rst_n;
  assign cfg_ch.ready = rst_n;

  assign out_ch.valid         = cmd_i.out_vld;
  assign out_ch.action        = res_r[rd_r].act;
  assign out_ch.tx_kind       = res_r[rd_r].kind;
  assign out_ch.tx_seq        = res_r[rd_r].seq;
  assign out_ch.tx_ack        = res_r[rd_r].ack;
  assign out_ch.payload       = res_r[rd_r].pay;
  assign out_ch.timer_seq     = res_r[rd_r].tseq;
  assign out_ch.transfer_done = done_r;
  assign out_ch.window_open   = (outst_r < SEQ_W'(WIN_DEPTH)) && (sent_r < fc_r);
  assign out_ch.last          = stat.res_last;

  `ARQ_ASSERT_IMP(a_rx_window_span, 1'b1, (rhe_r - rle_r) == SEQ_W'(WIN_DEPTH))
  `ARQ_ASSERT_IMP(a_res_bound, 1'b1, wcnt_r <= RES_IDX_W'(MAX_RESULTS))
  `ARQ_ASSERT_NXT(a_done_sticky, done_r, done_r)

endmodule

// ----- rtl/selective_repeat_arq_engine.sv -----
// Channel  Dir  Contents
// in_ch    in   event request: command, rx_kind, rx_seq, rx_ack, payloads, timed_out_seq
// out_ch   out  action run: action, frame fields, timer_seq, done/window flags, last
// cfg_ch   in   frame_count write (ready whenever out of reset)
//
// One request at a time: the controller latches it, dispatches it, then steps
// once per emitted action or window step, plus steps that emit nothing (store
// miss, loop exit, done check), then finishes and drains the results in order.
// Results are buffered so every one carries the flags of the finished event.
// Synchronous active-low reset; out_ch stalls simply hold the drain.
module selective_repeat_arq_engine
  import arq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  arq_in_if.sink    in_ch,
  arq_out_if.source out_ch,
  arq_cfg_if.sink   cfg_ch
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  arq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (dp_stat),
    .cmd_o (dp_cmd)
  );

  arq_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (dp_cmd),
    .stat   (dp_stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

// ----- sim/arq_checker.sv -----
module arq_checker
  import arq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  arq_in_if    in_ch,
  arq_out_if   out_ch,
  arq_cfg_if   cfg_ch,
  output int   pending,
  output int   errors
);

  typedef struct {
    act_e        act;
    logic [1:0]  kind;
    logic [2:0]  seq;
    logic [2:0]  ack;
    logic [31:0] pay;
    logic [2:0]  tseq;
    logic        done;
    logic        wopen;
    logic        last;
  } arq_action_t;

  // shadow of the engine
  logic [2:0]  snd_lo, snd_nxt, rcv_lo, rcv_hi;
  int          outstanding, completed, sent;
  logic        nak_ok, ooo, done;
  logic [3:0]  marks;
  logic [31:0] rx_store [4];
  logic [31:0] tx_store [4];
  logic [15:0] frame_cnt;

  arq_action_t run[$];
  arq_action_t expected_actions[$];

  assign pending = expected_actions.size();

  function automatic logic in_win(logic [2:0] a, logic [2:0] b, logic [2:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic void add(act_e act, logic [1:0] kind, logic [2:0] seq,
                              logic [31:0] pay, logic [2:0] tseq);
    arq_action_t r;
    if (run.size() >= MAX_RESULTS) return;
    r.act = act;
    r.kind = kind;
    r.seq = seq;
    r.ack = (act == ACT_TX) ? rcv_lo - 3'd1 : 3'd0;
    r.pay = pay;
    r.tseq = tseq;
    r.done = 0;
    r.wopen = 0;
    r.last = 0;
    run.push_back(r);
  endfunction

  function automatic void tx_frame(kind_e kind, logic [2:0] seq);
    if (kind == KIND_DATA) add(ACT_TX, KIND_DATA, seq, tx_store[seq[1:0]], 3'd0);
    else add(ACT_TX, kind, 3'd0, 32'd0, 3'd0);
    if (kind == KIND_NAK) nak_ok = 0;
    if (kind == KIND_DATA) add(ACT_START, 2'd0, 3'd0, 32'd0, seq);
    add(ACT_STOP_ACK, 2'd0, 3'd0, 32'd0, 3'd0);
  endfunction

  function automatic void bump(ref int c);
    if (c < 65535) c++;
  endfunction

  function automatic void check_done();
    if (completed == int'(frame_cnt)) done = 1;
  endfunction

  function automatic void on_frame(logic [1:0] kind, logic [2:0] seq, logic [2:0] ack,
                                   logic [31:0] rpay);
    logic [2:0] rs;
    if (kind == KIND_DATA) begin
      if (seq != rcv_lo) begin
        if (nak_ok) begin
          ooo = 1;
          tx_frame(KIND_NAK, 3'd0);
        end
      end else begin
        ooo = 0;
        add(ACT_START_ACK, 2'd0, 3'd0, 32'd0, 3'd0);
      end
      if (in_win(rcv_lo, seq, rcv_hi) && !marks[seq[1:0]]) begin
        marks[seq[1:0]] = 1;
        rx_store[seq[1:0]] = rpay;
        for (int i = 0; i < 4 && marks[rcv_lo[1:0]]; i++) begin
          add(ACT_DELIVER, 2'd0, 3'd0, rx_store[rcv_lo[1:0]], 3'd0);
          nak_ok = 1;
          marks[rcv_lo[1:0]] = 0;
          rcv_lo++;
          rcv_hi++;
          bump(completed);
          add(ACT_START_ACK, 2'd0, 3'd0, 32'd0, 3'd0);
        end
      end
    end
    if (kind == KIND_NAK) begin
      rs = ack + 3'd1;
      if (in_win(snd_lo, rs, snd_nxt)) tx_frame(KIND_DATA, rs);
    end
    for (int i = 0; i < 8 && in_win(snd_lo, ack, snd_nxt); i++) begin
      if (outstanding > 0) outstanding--;
      add(ACT_STOP, 2'd0, 3'd0, 32'd0, snd_lo);
      snd_lo++;
      bump(completed);
    end
    if ((kind == KIND_DATA && ooo) || kind == KIND_ACK || kind == KIND_NAK) check_done();
  endfunction

  function automatic void predict_request();
    run.delete();
    case (in_ch.command)
      CMD_SEND: begin
        if (outstanding < 7) outstanding++;
        tx_store[snd_nxt[1:0]] = in_ch.app_payload;
        tx_frame(KIND_DATA, snd_nxt);
        snd_nxt++;
        bump(sent);
      end
      CMD_FRAME: on_frame(in_ch.rx_kind, in_ch.rx_seq, in_ch.rx_ack, in_ch.rx_payload);
      CMD_TIMEOUT: tx_frame(KIND_DATA, in_ch.timed_out_seq);
      CMD_CKSUM_ERR: begin
        if (nak_ok) begin
          tx_frame(KIND_NAK, 3'd0);
          check_done();
        end
      end
      CMD_ACK_TMO: begin
        tx_frame(KIND_ACK, 3'd0);
        check_done();
      end
      default: ;
    endcase
    if (run.size() == 0) add(ACT_NONE, 2'd0, 3'd0, 32'd0, 3'd0);
    foreach (run[k]) begin
      run[k].done = done;
      run[k].wopen = (outstanding < WIN_DEPTH) && (sent < int'(frame_cnt));
      run[k].last = (k == run.size() - 1);
      expected_actions.push_back(run[k]);
    end
  endfunction

  function automatic void cmp(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $error("%s: expected %0h, got %0h", name, exp, got);
      errors++;
    end
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    arq_action_t e;
    if (!rst_n) begin
      snd_lo = 0; snd_nxt = 0; rcv_lo = 0; rcv_hi = 3'd4;
      outstanding = 0; completed = 0; sent = 0;
      nak_ok = 1; ooo = 0; done = 0; marks = 0;
      frame_cnt = 16'd1;
      expected_actions.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) frame_cnt = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) predict_request();
      if (out_ch.valid && out_ch.ready) begin
        if (expected_actions.size() == 0) begin
          $error("result with no request pending: action %0d", out_ch.action);
          errors++;
        end else begin
          e = expected_actions.pop_front();
          cmp("action", e.act, out_ch.action);
          cmp("tx_kind", e.kind, out_ch.tx_kind);
          cmp("tx_seq", e.seq, out_ch.tx_seq);
          cmp("tx_ack", e.ack, out_ch.tx_ack);
          cmp("payload", e.pay, out_ch.payload);
          cmp("timer_seq", e.tseq, out_ch.timer_seq);
          cmp("transfer_done", e.done, out_ch.transfer_done);
          cmp("window_open", e.wopen, out_ch.window_open);
          cmp("last", e.last, out_ch.last);
        end
      end
    end
  end

endmodule

// ----- sim/tb_selective_repeat_arq_engine.sv -----
module tb_selective_repeat_arq_engine;
  import arq_pkg::*;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam logic [1:0] KIND_RSVD   = 2'd3;
  localparam int         STALL_LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  int   pending, errors;
  int   in_count = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  int   cyc = 0;
  bit   held = 0;
  int   hold_left = 0;

  // stimulus-side view of the windows, used only to shape well-formed traffic
  logic [2:0] tx_base = 0, tx_next = 0, rx_base = 0;

  always #5 clk = ~clk;

  arq_in_if  in_ch();
  arq_out_if out_ch();
  arq_cfg_if cfg_ch();

  selective_repeat_arq_engine dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  arq_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .pending(pending), .errors(errors)
  );

  function automatic logic in_win(logic [2:0] a, logic [2:0] b, logic [2:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  // receiver: rotating stall patterns, one long hold-off after 150 requests have been taken
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!held && in_count == 150) begin
      held <= 1;
      hold_left <= 400;
      out_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else begin
      case ((cyc / 200) % 3)
        0: out_ch.ready <= 1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic put(logic [2:0] c, logic [1:0] k, logic [2:0] s, logic [2:0] a,
                     logic [31:0] rp, logic [31:0] ap, logic [2:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.command <= c;
    in_ch.rx_kind <= k;
    in_ch.rx_seq <= s;
    in_ch.rx_ack <= a;
    in_ch.rx_payload <= rp;
    in_ch.app_payload <= ap;
    in_ch.timed_out_seq <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_count++;
    if (c == CMD_SEND) tx_next++;
    if (c == CMD_FRAME && in_win(tx_base, a, tx_next)) tx_base = a + 3'd1;
  endtask

  task automatic frame(logic [1:0] k, logic [2:0] s, logic [2:0] a);
    put(CMD_FRAME, k, s, a, $urandom, $urandom, 3'($urandom_range(0, 7)));
  endtask

  task automatic event_only(logic [2:0] c);
    put(c, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
        $urandom, $urandom, 3'($urandom_range(0, 7)));
  endtask

  task automatic write_frame_count(logic [15:0] v);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    burst_left = 0;
  endtask

  initial begin
    logic [2:0] perm [4];
    logic [2:0] t;
    int j, n;

    in_ch.valid = 0;
    in_ch.command = CMD_SEND;
    in_ch.rx_kind = KIND_DATA;
    in_ch.rx_seq = 0;
    in_ch.rx_ack = 0;
    in_ch.rx_payload = 0;
    in_ch.app_payload = 0;
    in_ch.timed_out_seq = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_frame_count(16'd3);
    // directed: fill every send store slot before any retransmit
    put(CMD_SEND, KIND_DATA, 0, 0, 0, 32'h0000_0000, 0);
    put(CMD_SEND, KIND_DATA, 0, 0, 0, 32'hFFFF_FFFF, 0);
    put(CMD_SEND, KIND_DATA, 0, 0, 0, $urandom, 0);
    put(CMD_SEND, KIND_DATA, 0, 0, 0, 32'hA5A5_5A5A, 0);
    put(CMD_TIMEOUT, KIND_DATA, 0, 0, 0, 0, 3'd0);
    put(CMD_TIMEOUT, KIND_DATA, 0, 0, 0, 0, 3'd7);
    put(CMD_CKSUM_ERR, KIND_DATA, 0, 0, 0, 0, 0);
    put(CMD_CKSUM_ERR, KIND_DATA, 0, 0, 0, 0, 0);   // NAK already spent
    put(CMD_ACK_TMO, KIND_DATA, 0, 0, 0, 0, 0);
    put(CMD_FRAME, KIND_DATA, 3'd0, 3'd7, 32'hFFFF_FFFF, 0, 0);
    put(CMD_FRAME, KIND_DATA, 3'd2, 3'd7, 32'h0000_0000, 0, 0);  // out of order
    put(CMD_FRAME, KIND_DATA, 3'd1, 3'd7, 32'h1234_5678, 0, 0);  // fills gap
    put(CMD_FRAME, KIND_ACK, 0, 3'd1, 0, 0, 0);
    put(CMD_FRAME, KIND_NAK, 0, 3'd1, 0, 0, 0);       // retransmit inside window
    put(CMD_FRAME, KIND_RSVD, 3'd7, 3'd3, 0, 0, 0);
    put(CMD_FRAME, KIND_NAK, 0, 3'd6, 0, 0, 0);       // outside window
    put(CMD_FRAME, KIND_DATA, 3'd7, 3'd0, 32'hFFFF_FFFF, 0, 0); // beyond receive window
    put(CMD_RSVD_LO, KIND_DATA, 0, 0, 0, 0, 0);
    put(CMD_RSVD_HI, KIND_DATA, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++)   // overrun the send window
      put(CMD_SEND, KIND_DATA, 0, 0, 0, $urandom, 0);
    rx_base = 3'd3;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_frame_count(16'd1);
        1: write_frame_count(16'hFFFF);
        2: write_frame_count(16'($urandom_range(2, 40)));
        default: write_frame_count(16'($urandom_range(1, 65535)));
      endcase
      while (in_count < 30 + (ph + 1) * 100) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n && 3'(tx_next - tx_base) < 6; i++)
              put(CMD_SEND, KIND_DATA, 0, 0, 0, $urandom, 0);
            if (tx_next != tx_base)
              frame($urandom_range(0, 1) ? KIND_ACK : KIND_NAK, 3'($urandom_range(0, 7)),
                    tx_base + 3'($urandom_range(0, 3'(tx_next - tx_base) - 1)));
          end
          4, 5, 6: begin
            for (int i = 0; i < 4; i++) perm[i] = rx_base + 3'(i);
            for (int i = 3; i > 0; i--) begin
              j = $urandom_range(0, i);
              t = perm[i]; perm[i] = perm[j]; perm[j] = t;
            end
            for (int i = 0; i < 4; i++) frame(KIND_DATA, perm[i], 3'($urandom_range(0, 7)));
            rx_base += 3'd4;
          end
          7: event_only(3'($urandom_range(CMD_TIMEOUT, CMD_ACK_TMO)));
          8: frame($urandom_range(0, 1) ? KIND_RSVD : KIND_NAK, 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)));
          default: begin
            case ($urandom_range(0, 2))
              0: event_only(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)));
              1: frame(KIND_DATA, rx_base + 3'($urandom_range(4, 7)),
                       3'($urandom_range(0, 7)));
              default: put(CMD_SEND, KIND_DATA, 0, 0, 0, $urandom, 0);
            endcase
          end
        endcase
      end
    end

    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
